/* design/nbbrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbrf_pkg
// Shared constants, types and the control store of the 9-bit bus framer.
// ----------------------------------------------------------------------------
package nbbrf_pkg;

  // Packet store geometry
  localparam int MAX_PACKET = 32;
  localparam int PKT_AW     = $clog2(MAX_PACKET);
  localparam int FILL_W     = $clog2(MAX_PACKET + 1);
  localparam int RUN_CAP    = (MAX_PACKET < 32) ? MAX_PACKET : 32;

  // Fixed field widths
  localparam int WORD_W = 9;
  localparam int ADDR_W = 5;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 6;
  localparam int KIND_W = 2;
  localparam int REM_W  = 6;
  localparam int CFGI_W = 2;

  localparam logic [REM_W-1:0]  REM_IDLE   = 6'h3F;
  localparam logic [WORD_W-1:0] BCAST_WORD = 9'h160;
  localparam logic [6:0]        INQ_BITS   = 7'h40;
  localparam logic [6:0]        RSP_BITS   = 7'h60;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd2;

  // Register indexes
  localparam logic [CFGI_W-1:0] REG_OWN_ADDRESS = 2'd0;
  localparam logic [CFGI_W-1:0] REG_LISTEN_ALL  = 2'd1;

  // Sequencer steps
  typedef enum logic [3:0] {
    S_FETCH    = 4'd0,
    S_CLASSIFY = 4'd1,
    S_EVENT    = 4'd2,
    S_BEGIN    = 4'd3,
    S_STORE    = 4'd4,
    S_FINISH   = 4'd5,
    S_RUN_ADDR = 4'd6,
    S_RUN_EMIT = 4'd7,
    S_RUN_TEST = 4'd8,
    S_RUN_NEXT = 4'd9
  } step_t;

  // Jump conditions; ACCEPT and OUT_FREE also gate the step's operations
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_ACCEPT   = 3'd1,
    C_OUT_FREE = 3'd2,
    C_DISPATCH = 3'd3,
    C_LAST     = 3'd4
  } cond_t;

  typedef struct packed {
    logic  ready;
    logic  take_in;
    logic  clr_idx;
    logic  do_begin;
    logic  do_store;
    logic  do_finish;
    logic  load_evt;
    logic  load_byte;
    logic  idx_inc;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ctrl_t;

  // Call word: bit 8 set, bit 7 makes the low byte even
  function automatic logic [WORD_W-1:0] call_word(input logic [6:0] low7);
    return {1'b1, ^low7, low7};
  endfunction

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{ready: 1'b0, take_in: 1'b0, clr_idx: 1'b0, do_begin: 1'b0,
          do_store: 1'b0, do_finish: 1'b0, load_evt: 1'b0, load_byte: 1'b0,
          idx_inc: 1'b0, cond: C_ALWAYS, tgt_t: S_FETCH, tgt_f: S_FETCH};
    case (s)
      S_FETCH: begin
        w.ready = 1'b1; w.take_in = 1'b1; w.clr_idx = 1'b1;
        w.cond = C_ACCEPT; w.tgt_t = S_CLASSIFY; w.tgt_f = S_FETCH;
      end
      S_CLASSIFY: begin
        w.cond = C_DISPATCH;
      end
      S_EVENT: begin
        w.load_evt = 1'b1;
        w.cond = C_OUT_FREE; w.tgt_t = S_FETCH; w.tgt_f = S_EVENT;
      end
      S_BEGIN: begin
        w.do_begin = 1'b1;
      end
      S_STORE: begin
        w.do_store = 1'b1;
      end
      S_FINISH: begin
        w.do_finish = 1'b1;
      end
      S_RUN_ADDR: begin
        w.tgt_t = S_RUN_EMIT;
      end
      S_RUN_EMIT: begin
        w.load_byte = 1'b1;
        w.cond = C_OUT_FREE; w.tgt_t = S_RUN_TEST; w.tgt_f = S_RUN_EMIT;
      end
      S_RUN_TEST: begin
        w.cond = C_LAST; w.tgt_t = S_FINISH; w.tgt_f = S_RUN_NEXT;
      end
      S_RUN_NEXT: begin
        w.idx_inc = 1'b1; w.tgt_t = S_RUN_ADDR;
      end
      default: begin
        w.tgt_t = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/nbbrf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbbrf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nbbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/nine_bit_bus_receive_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_bit_bus_receive_framer
// Client-side receive framer for a 9-bit call-bit bus, run by a microcode ROM.
// ----------------------------------------------------------------------------
// Feed one received bus word per input beat; the block answers inquiry and
// acknowledge calls to its own address with a single-beat event, and gathers
// response and broadcast packets into a 32-byte store. The word after the
// last packet byte completes the packet: its stored bytes leave as a run of
// byte beats with tlast on the final one, or are dropped when queue_full was
// set on that completing word. An ignored word passes through a fetch step and
// a classify step; a stored, starting or dropping word adds an action step;
// an event beat adds an event step that also waits out any output stall; a
// completing word runs, for each byte, an address step, an emit step that
// waits out output stalls and a test step around the store's registered read,
// with an advance step between bytes and a closing step after the last one.
// The sequencer executes one control word per cycle.
// Configuration writes are taken at any time, but only while idle are they
// meant to be issued.
// ----------------------------------------------------------------------------
module nine_bit_bus_receive_framer
  import nbbrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input beats
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [8:0] bus_word, zero fill above
  input  logic [1:0]        s_tuser,   // [0] rx_error, [1] queue_full
  // result beats
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // [7:0] packet_byte, [12:8] byte_index,
                                       // [18:13] packet_length, zero fill above
  output logic [1:0]        m_tuser,   // [1:0] event_kind
  output logic              m_tlast,   // last_byte
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  // Sequencer
  step_t step;
  step_t step_next;
  step_t dispatch_step;
  ctrl_t cw;
  logic  fire;

  // Datapath registers
  logic [WORD_W-1:0] in_word;
  logic              in_err;
  logic              in_full;
  logic [REM_W-1:0]  remaining;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] run_idx;
  logic [ADDR_W-1:0] own_address;
  logic              listen_all;

  // Datapath values
  logic              hit_inq;
  logic              hit_rsp;
  logic              hit_ack;
  logic              reading;
  logic              starts;
  logic [BYTE_W-1:0] in_byte;
  logic [3:0]        in_nib;
  logic [FILL_W-1:0] run_len;
  logic              run_last;
  logic              out_free;
  logic              accept;
  logic              store_wr;
  logic [BYTE_W-1:0] rd_byte;

  assign cw       = ucode(step);
  assign s_tready = cw.ready;
  assign cfg_ready = 1'b1;
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // An error word reads as all ones: no call match, byte 0xFF, nibble 0xF
  assign in_byte = in_err ? '1 : in_word[BYTE_W-1:0];
  assign in_nib  = in_err ? 4'hF : in_word[3:0];
  assign hit_inq = ~in_err & (in_word == call_word(INQ_BITS | {2'b00, own_address}));
  assign hit_rsp = ~in_err & (in_word == call_word(RSP_BITS | {2'b00, own_address}));
  assign hit_ack = ~in_err & (in_word == call_word({2'b00, own_address}));
  assign reading = (remaining != '0) && (remaining <= REM_W'(31));
  assign starts  = (~in_err & (in_word == BCAST_WORD))
                 | (listen_all & (in_err | in_word[WORD_W-1]));

  // Classify the held word: calls first, then packet state
  always_comb begin
    if (hit_inq || hit_ack) begin
      dispatch_step = S_EVENT;
    end else if (hit_rsp) begin
      dispatch_step = S_BEGIN;
    end else if (reading) begin
      dispatch_step = S_STORE;
    end else if (remaining == '0) begin
      dispatch_step = (!in_full && fill != '0) ? S_RUN_ADDR : S_FINISH;
    end else if (starts) begin
      dispatch_step = S_BEGIN;
    end else begin
      dispatch_step = S_FETCH;
    end
  end

  assign run_len  = (fill > FILL_W'(RUN_CAP)) ? FILL_W'(RUN_CAP) : fill;
  assign run_last = ((run_idx + FILL_W'(1)) == run_len);

  // Operations fire only once a wait condition is met
  always_comb begin
    case (cw.cond)
      C_ACCEPT:   fire = accept;
      C_OUT_FREE: fire = out_free;
      default:    fire = 1'b1;
    endcase
  end

  always_comb begin
    case (cw.cond)
      C_ALWAYS:   step_next = cw.tgt_t;
      C_ACCEPT:   step_next = accept   ? cw.tgt_t : cw.tgt_f;
      C_OUT_FREE: step_next = out_free ? cw.tgt_t : cw.tgt_f;
      C_DISPATCH: step_next = dispatch_step;
      C_LAST:     step_next = run_last ? cw.tgt_t : cw.tgt_f;
      default:    step_next = S_FETCH;
    endcase
  end

  // Drop bytes beyond the store
  assign store_wr = cw.do_store & (fill < FILL_W'(MAX_PACKET));

  nbbrf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PACKET)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (fill[PKT_AW-1:0]),
    .wr_data (in_byte),
    .rd_addr (run_idx[PKT_AW-1:0]),
    .rd_data (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= S_FETCH;
      remaining   <= REM_IDLE;
      fill        <= '0;
      run_idx     <= '0;
      own_address <= ADDR_W'(1);
      listen_all  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      step <= step_next;

      // Configuration; indexes beyond the list are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OWN_ADDRESS: own_address <= cfg_data;
          REG_LISTEN_ALL:  listen_all  <= cfg_data[0];
          default: ;
        endcase
      end

      // Load a new beat, else retire a taken one
      if (fire && (cw.load_evt || cw.load_byte)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (fire && cw.take_in) begin
        in_word <= s_tdata[WORD_W-1:0];
        in_err  <= s_tuser[0];
        in_full <= s_tuser[1];
      end
      if (fire && cw.clr_idx) begin
        run_idx <= '0;
      end
      if (cw.idx_inc) begin
        run_idx <= run_idx + FILL_W'(1);
      end

      if (cw.do_begin) begin
        remaining <= REM_W'(1);
        fill      <= '0;
      end
      // First byte is the header: its nibble plus one is the count of further bytes
      if (cw.do_store) begin
        if (fill == '0) begin
          remaining <= REM_W'(in_nib) + REM_W'(1);
        end else begin
          remaining <= remaining - REM_W'(1);
        end
        if (store_wr) begin
          fill <= fill + FILL_W'(1);
        end
      end
      if (cw.do_finish) begin
        remaining <= REM_IDLE;
        fill      <= '0;
      end

      if (fire && cw.load_evt) begin
        m_tuser  <= hit_inq ? KIND_WINDOW : KIND_ACK;
        m_tdata  <= '0;
        m_tlast  <= 1'b1;
      end
      if (fire && cw.load_byte) begin
        m_tuser  <= KIND_BYTE;
        m_tdata  <= {5'b0, LEN_W'(run_len), run_idx[IDX_W-1:0], rd_byte};
        m_tlast  <= run_last;
      end
    end
  end

  // No new word is taken while a run is in flight
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    (step == S_RUN_EMIT || step == S_RUN_ADDR || step == S_RUN_TEST) |-> !s_tready)
    else $error("input accepted during a packet run");

  // A byte beat sits inside its packet
  a_index_in_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE) |-> (m_tdata[12:8] < m_tdata[18:13]))
    else $error("byte index beyond packet length");

  // tlast marks exactly the final byte of a run
  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_BYTE) |->
      (m_tlast == ((m_tdata[12:8] + 6'd1) == m_tdata[18:13])))
    else $error("tlast does not match byte position");

  // Fill never passes the store
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_PACKET))
    else $error("fill position beyond store");

  // Byte count is idle or a header count
  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    (remaining == REM_IDLE) || (remaining <= REM_W'(16)))
    else $error("byte count out of range");

  // A completing word goes back to idle
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (step == S_FINISH) |=> (remaining == REM_IDLE && fill == '0))
    else $error("packet not closed after finish");

endmodule

/* sim/nine_bit_bus_receive_framer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_bit_bus_receive_framer_tb
// Self-checking bench for the 9-bit bus receive framer.
// ----------------------------------------------------------------------------
// Drive bus words into the framer and predict every event and packet byte
// with a cycle-free model of the client. A monitor compares each output beat
// with the oldest prediction. Directed tests cover call words, packets,
// receive errors, dropped packets and listen-all mode. Random phases then run
// well-formed packets mixed with calls and noise under several idling mixes.
// ----------------------------------------------------------------------------
module nine_bit_bus_receive_framer_tb;
  import nbbrf_pkg::*;

  localparam logic [CFGI_W-1:0] REG_UNUSED  = 2'd3;  // no register behind it
  localparam logic [15:0]       RX_ERR_WORD = 16'hFFFF;
  localparam logic [15:0]       CALL_BIT    = 16'h0100;
  localparam int                SETTLE      = 40;     // cycles after the last beat
  localparam int                RUN_LIMIT_NS = 5000000; // end of a hung run

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len;
    logic              last;
  } framer_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;   // [8:0] bus_word
  logic [1:0]        s_tuser = '0;   // [0] rx_error, [1] queue_full
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;        // [7:0] byte, [12:8] index, [18:13] length
  logic [1:0]        m_tuser;        // [1:0] event_kind
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  // Client model: registers, packet counter and byte store
  logic [ADDR_W-1:0] tb_addr;
  logic              tb_listen;
  logic [REM_W-1:0]  bytes_left;
  logic [5:0]        fill_pos;
  logic [BYTE_W-1:0] pkt_bytes [MAX_PACKET];

  framer_beat_t pending_beats[$];
  int           err_count = 0;
  int           items_sent = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;

  nine_bit_bus_receive_framer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hard stop in case the framer hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: honor a long hold-off first, otherwise stall at the phase rate
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: compare every output beat with the oldest prediction
  always @(posedge clk) begin : check_beats
    framer_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected beat: kind %0d byte %02h index %0d length %0d last %0b",
                   m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[18:13], m_tlast);
      end else begin
        want = pending_beats.pop_front();
        if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
            m_tdata[12:8] !== want.idx || m_tdata[18:13] !== want.len ||
            m_tlast !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display({"beat mismatch: expected kind %0d byte %02h index %0d length %0d",
                      " last %0b, got kind %0d byte %02h index %0d length %0d last %0b"},
                     want.kind, want.data, want.idx, want.len, want.last,
                     m_tuser, m_tdata[7:0], m_tdata[12:8], m_tdata[18:13], m_tlast);
        end
      end
    end
  end

  // Call word for the low seven bits: call bit set, bit 7 evens out the byte
  function automatic logic [8:0] call_of(input logic [6:0] low7);
    logic p;
    p = 1'b0;
    for (int i = 0; i < 7; i++) p = p ^ low7[i];
    return {1'b1, p, low7};
  endfunction

  // Advance the client model by one received word and queue the beats it causes
  task automatic frame_word(input logic [8:0] word, input logic err, input logic full);
    logic [15:0]      w;
    logic [LEN_W-1:0] n;
    framer_beat_t     b;
    w = err ? RX_ERR_WORD : {7'd0, word};
    b = '{kind: KIND_WINDOW, data: '0, idx: '0, len: '0, last: 1'b1};
    if (w == {7'd0, call_of({2'b10, tb_addr})}) begin
      pending_beats.push_back(b);
    end else if (w == {7'd0, call_of({2'b11, tb_addr})}) begin
      // Response to us: (re)start a packet, even mid-packet
      bytes_left = 6'd1;
      fill_pos = '0;
    end else if (w == {7'd0, call_of({2'b00, tb_addr})}) begin
      b.kind = KIND_ACK;
      pending_beats.push_back(b);
    end else if (bytes_left >= 6'd1 && bytes_left <= 6'd31) begin
      bytes_left = bytes_left - 6'd1;
      if (fill_pos == '0) bytes_left = {2'b00, w[3:0]} + 6'd1;  // header sets length
      if (fill_pos < MAX_PACKET) begin
        pkt_bytes[fill_pos[PKT_AW-1:0]] = w[7:0];
        fill_pos = fill_pos + 6'd1;
      end
    end else if (bytes_left == '0) begin
      // Completion word: emit the run unless the queue is full, then go idle
      if (!full) begin
        n = (fill_pos > RUN_CAP) ? LEN_W'(RUN_CAP) : fill_pos;
        for (int i = 0; i < n; i++) begin
          b = '{kind: KIND_BYTE, data: pkt_bytes[PKT_AW'(i)], idx: IDX_W'(i), len: n,
                last: (i + 1 == n)};
          pending_beats.push_back(b);
        end
      end
      bytes_left = REM_IDLE;
      fill_pos = '0;
    end else if (w == {7'd0, BCAST_WORD} || (tb_listen && w >= CALL_BIT)) begin
      bytes_left = 6'd1;
      fill_pos = '0;
    end
  endtask

  // Offer one word; idle first at the phase rate, predict on acceptance
  task automatic send_word(input logic [8:0] word, input logic err, input logic full);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, word};
    s_tuser  <= {full, err};
    do @(posedge clk); while (!s_tready);
    frame_word(word, err, full);
    items_sent++;
  endtask

  // Drop valid, wait for every predicted beat, then let the framer settle
  task automatic wait_drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_OWN_ADDRESS) tb_addr = val;
    else if (idx == REG_LISTEN_ALL) tb_listen = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // One random exchange: mostly well-formed packets, plus calls and noise
  task automatic random_exchange;
    int pick;
    int r;
    int nib;
    pick = $urandom_range(99);
    if (pick < 55) begin
      r = $urandom_range(99);
      if (tb_listen && r >= 80) begin
        if ($urandom_range(3) == 0)
          send_word(9'($urandom_range(511)), 1'b1, 1'($urandom_range(1)));
        else
          send_word({1'b1, 8'($urandom_range(255))}, 1'b0, 1'($urandom_range(1)));
      end else if (r < 55) begin
        send_word(call_of({2'b11, tb_addr}), 1'b0, 1'($urandom_range(1)));
      end else begin
        send_word(BCAST_WORD, 1'b0, 1'($urandom_range(1)));
      end
      // Keep most packets short; a few reach the full 17 bytes
      nib = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15);
      send_word({5'($urandom_range(31)), 4'(nib)}, $urandom_range(99) < 3,
                1'($urandom_range(1)));
      for (int k = 0; k <= nib; k++)
        send_word(9'($urandom_range(511)), $urandom_range(99) < 5,
                  1'($urandom_range(1)));
      send_word(9'($urandom_range(511)), $urandom_range(99) < 5,
                $urandom_range(99) < 25);
    end else if (pick < 67) begin
      send_word(call_of({2'b10, tb_addr}), 1'b0, 1'($urandom_range(1)));
    end else if (pick < 79) begin
      send_word(call_of({2'b00, tb_addr}), 1'b0, 1'($urandom_range(1)));
    end else begin
      send_word(9'($urandom_range(511)), $urandom_range(99) < 10,
                1'($urandom_range(1)));
    end
    // Now and then pause the sender until the framer is empty
    if ($urandom_range(99) < 4) wait_drain();
  endtask

  // Reset address answers inquiry and acknowledge; a stray data word is ignored
  task automatic test_call_events;
    send_word(9'h055, 1'b0, 1'b0);
    send_word(call_of({2'b10, tb_addr}), 1'b0, 1'b0);
    send_word(call_of({2'b00, tb_addr}), 1'b0, 1'b1);
  endtask

  // Shortest packet: header with nibble zero, one byte, completion
  task automatic test_short_packet;
    send_word(call_of({2'b11, tb_addr}), 1'b0, 1'b0);
    send_word(9'h000, 1'b0, 1'b0);
    send_word(9'h1FF, 1'b0, 1'b0);
    send_word(9'h000, 1'b0, 1'b0);
  endtask

  // Broadcast packet holding an error byte; full queue drops it
  task automatic test_error_and_drop;
    send_word(BCAST_WORD, 1'b0, 1'b0);
    send_word(9'h001, 1'b0, 1'b0);
    send_word(9'h0A5, 1'b1, 1'b0);
    send_word(9'h0FF, 1'b0, 1'b0);
    send_word(9'h000, 1'b0, 1'b1);
  endtask

  // Calls inside a packet act at once; a second response restarts it
  task automatic test_calls_in_packet;
    send_word(call_of({2'b11, tb_addr}), 1'b0, 1'b0);
    send_word(9'h002, 1'b0, 1'b0);
    send_word(call_of({2'b10, tb_addr}), 1'b0, 1'b0);
    send_word(call_of({2'b00, tb_addr}), 1'b0, 1'b0);
    send_word(9'h1AA, 1'b0, 1'b0);
    send_word(call_of({2'b11, tb_addr}), 1'b0, 1'b0);
    send_word(9'h000, 1'b0, 1'b0);
    send_word(9'h155, 1'b0, 1'b0);
    send_word(9'h0C3, 1'b0, 1'b0);
    wait_drain();
  endtask

  // Listen-all: an error word starts a packet when idle; unused index is ignored
  task automatic test_listen_all;
    write_reg(REG_UNUSED, 5'h1F);
    write_reg(REG_LISTEN_ALL, 5'h01);
    send_word(9'h000, 1'b1, 1'b0);
    send_word(9'h0F0, 1'b0, 1'b0);
    send_word(9'h000, 1'b0, 1'b0);
    send_word(9'h1FE, 1'b0, 1'b0);
    wait_drain();
  endtask

  // Hold the receiver off while inquiries pile up, then drain completely
  task automatic test_backpressure;
    set_idling(0, 0);
    hold_left = 400;
    for (int k = 0; k < 10; k++) send_word(call_of({2'b10, tb_addr}), 1'b0, 1'b0);
    send_word(BCAST_WORD, 1'b0, 1'b0);
    send_word(9'h003, 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) send_word(9'($urandom_range(511)), 1'b0, 1'b0);
    send_word(9'h000, 1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_phase(input logic [ADDR_W-1:0] addr, input logic listen,
                                   input int send_pct, input int recv_pct);
    int stop_at;
    write_reg(REG_OWN_ADDRESS, addr);
    write_reg(REG_LISTEN_ALL, {4'($urandom_range(15)), listen});
    set_idling(send_pct, recv_pct);
    stop_at = items_sent + 57;
    while (items_sent < stop_at) random_exchange();
    wait_drain();
  endtask

  initial begin
    tb_addr = 5'd1;
    tb_listen = 1'b0;
    bytes_left = REM_IDLE;
    fill_pos = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_call_events();
    test_short_packet();
    test_error_and_drop();
    test_calls_in_packet();
    test_listen_all();
    test_backpressure();
    test_random_phase(5'($urandom_range(1, 30)), 1'b0, 0, 0);
    test_random_phase(5'd0, 1'b1, 72, 0);
    test_random_phase(5'd31, 1'b0, 0, 72);
    test_random_phase(5'($urandom_range(31)), 1'b1, 22, 22);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
design/nbbrf_pkg.sv
design/nbbrf_ram.sv
design/nine_bit_bus_receive_framer.sv
sim/nine_bit_bus_receive_framer_tb.sv
